FILE: rtl/uspd_pkg.sv
`default_nettype none
package uspd_pkg;

    typedef logic [1:0] t_seg;

    localparam t_seg SEG_PATH  = 2'd0;
    localparam t_seg SEG_QUERY = 2'd1;
    localparam t_seg SEG_FRAG  = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_HASH    = 8'h23;

    // escape progress
    typedef enum logic [2:0] {
        PH_NONE   = 3'b001,
        PH_FIRST  = 3'b010,
        PH_SECOND = 3'b100
    } t_phase;

    typedef struct packed {
        t_seg       seg;
        logic       query_seen;
        t_phase     phase;
        logic [7:0] acc;
        logic       stopped;
        logic       err;
    } t_state;

    localparam t_state ST_RESET = '{
        seg:        SEG_PATH,
        query_seen: 1'b0,
        phase:      PH_NONE,
        acc:        8'h00,
        stopped:    1'b0,
        err:        1'b0
    };

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        t_seg       seg;
        logic       err;
        logic       done;
    } t_res;

    // {is_hex, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
                hex_digit = {1'b1, d[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
                hex_digit = {1'b1, d[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
                hex_digit = {1'b1, d[3:0]};
            end else begin
                hex_digit = 5'h00;
            end
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/uspd_step.sv
`default_nettype none
module uspd_step (
    input  wire uspd_pkg::t_state i_state,
    input  wire [7:0]             i_byte,
    input  wire                   i_last,
    output uspd_pkg::t_state      o_next,
    output uspd_pkg::t_res        o_res
);
    import uspd_pkg::*;

    logic [4:0] hx;
    logic       delim;
    t_state     ns;

    always_comb begin
        ns = i_state;
        o_res = '0;
        hx = hex_digit(i_byte);
        delim = (i_state.seg == SEG_PATH && (i_byte == CH_QUEST || i_byte == CH_HASH))
             || (i_state.seg == SEG_QUERY && i_byte == CH_HASH);

        if (i_state.seg == SEG_FRAG && i_byte == CH_QUEST && !i_state.query_seen) begin
            ns.err = 1'b1;
        end

        if (delim) begin
            // a pending escape is dropped
            ns.phase   = PH_NONE;
            ns.acc     = 8'h00;
            ns.stopped = 1'b0;
            if (i_byte == CH_QUEST) begin
                ns.seg        = SEG_QUERY;
                ns.query_seen = 1'b1;
            end else begin
                ns.seg = SEG_FRAG;
            end
        end else begin
            case (i_state.phase)
                PH_FIRST: begin
                    if (hx[4]) begin
                        ns.acc = {4'h0, hx[3:0]};
                    end else begin
                        ns.stopped = 1'b1;
                    end
                    ns.phase = PH_SECOND;
                end
                PH_SECOND: begin
                    o_res.out_valid = 1'b1;
                    if (!i_state.stopped && hx[4]) begin
                        o_res.out_byte = {i_state.acc[3:0], hx[3:0]};
                    end else begin
                        o_res.out_byte = i_state.acc;
                    end
                    ns.phase   = PH_NONE;
                    ns.acc     = 8'h00;
                    ns.stopped = 1'b0;
                end
                default: begin
                    if (i_byte == CH_PERCENT) begin
                        ns.phase   = PH_FIRST;
                        ns.acc     = 8'h00;
                        ns.stopped = 1'b0;
                    end else begin
                        o_res.out_valid = 1'b1;
                        o_res.out_byte  = i_byte;
                    end
                    if (i_state.phase != PH_FIRST && i_state.phase != PH_SECOND
                        && i_byte != CH_PERCENT) begin
                        ns.phase = PH_NONE;
                    end
                end
            endcase
        end

        o_res.seg  = ns.seg;
        o_res.err  = ns.err;
        o_res.done = i_last;

        // end of URI: start the next one clean
        o_next = i_last ? ST_RESET : ns;
    end

endmodule
`default_nettype wire

FILE: rtl/uri_split_percent_decode.sv
`default_nettype none
// Channel   Dir  Handshake                  Payload
// --------  ---  -------------------------  ----------------------------------------
// in        in   i_in_valid / o_in_stall    i_in_byte, i_is_last
// res       out  o_res_valid / i_res_stall  o_out_valid, o_out_byte, o_segment,
//                                            o_parse_error, o_done_res
//
// One request per cycle sustained while the result is not stalled; a request passes
// the input register, then the result register. The per-byte state update is one
// short step between them. Reset (synchronous, active low) returns to the path
// segment with no error. A stalled result holds; the input register still takes one
// more request, after which o_in_stall rises until the result is taken.
module uri_split_percent_decode (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire [7:0]  i_in_byte,
    input  wire        i_is_last,
    output logic       o_res_valid,
    input  wire        i_res_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_segment,
    output logic       o_parse_error,
    output logic       o_done_res
);
    import uspd_pkg::*;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parser state and result register
    t_state r_state;
    t_state n_state;
    t_res   n_res;
    t_res   r_res;
    logic   r_res_vld;

    logic   advance;

    // stage 1 moves when the result register is free or being emptied
    assign advance    = r_in_vld && (!r_res_vld || !i_res_stall);
    assign o_in_stall = r_in_vld && !advance;

    uspd_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_next  (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_res_vld <= 1'b0;
            r_state   <= ST_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_state   <= n_state;
                r_res_vld <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_is_last;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid   = r_res_vld;
    assign o_out_valid   = r_res.out_valid;
    assign o_out_byte    = r_res.out_byte;
    assign o_segment     = r_res.seg;
    assign o_parse_error = r_res.err;
    assign o_done_res    = r_res.done;

endmodule
`default_nettype wire

FILE: rtl/uspd_chk.sv
`default_nettype none
module uspd_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_in_stall,
    input wire       o_res_valid,
    input wire       i_res_stall,
    input wire       o_out_valid,
    input wire [7:0] o_out_byte,
    input wire [1:0] o_segment,
    input wire       o_parse_error,
    input wire       o_done_res
);
    import uspd_pkg::*;

    // input side only backs up behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_res_valid && i_res_stall))
        else $error("input stalled without blocked result");

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_stall) |=> (o_res_valid && $stable(o_out_valid)
            && $stable(o_out_byte) && $stable(o_segment)
            && $stable(o_parse_error) && $stable(o_done_res)))
        else $error("stalled result changed");

    a_seg_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_segment == SEG_PATH || o_segment == SEG_QUERY
            || o_segment == SEG_FRAG))
        else $error("bad segment code");

    // the error arises only in the fragment, which nothing leaves before the end
    a_err_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_parse_error) |-> (o_segment == SEG_FRAG))
        else $error("parse error outside fragment");

    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_out_valid) |-> (o_out_byte == 8'h00))
        else $error("data byte without out_valid");

endmodule

bind uri_split_percent_decode uspd_chk u_chk (.*);
`default_nettype wire
